// ----- sv/sdc_pkg.sv -----
package sdc_pkg;

  // sizes
  localparam int NUM_SIGNALS = 64;
  localparam int NEST_DEPTH  = 8;
  localparam int SET_W       = 64;
  localparam int SIGNUM_W    = 6;
  localparam int SIG_W       = $clog2(NUM_SIGNALS);
  localparam int LVL_W       = $clog2(NEST_DEPTH + 1);
  localparam int STK_AW      = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
  localparam int FLAG_W      = 5;
  localparam int DISP_W      = FLAG_W + SET_W;

  // special signal numbers
  localparam logic [SIGNUM_W-1:0] SIG_KILL  = 6'd9;
  localparam logic [SIGNUM_W-1:0] SIG_STOP  = 6'd19;
  localparam logic [SIGNUM_W-1:0] SIG_CHLD  = 6'd17;
  localparam logic [SIGNUM_W-1:0] SIG_URG   = 6'd23;
  localparam logic [SIGNUM_W-1:0] SIG_WINCH = 6'd28;

  // signal set masks
  localparam logic [SET_W-1:0] ALL_SIG =
    (NUM_SIGNALS >= SET_W) ? {SET_W{1'b1}} : ((64'd1 << NUM_SIGNALS) - 64'd1);
  localparam logic [SET_W-1:0] VALID_MASK  = ALL_SIG & ~64'd1;
  localparam logic [SET_W-1:0] DFL_IGN     =
    ((64'd1 << SIG_CHLD) | (64'd1 << SIG_URG) | (64'd1 << SIG_WINCH)) & VALID_MASK;
  localparam logic [SET_W-1:0] UNBLOCKABLE = (64'd1 << SIG_KILL) | (64'd1 << SIG_STOP);

  typedef enum logic [2:0] {
    ACT_POST    = 3'd0,
    ACT_SETDISP = 3'd1,
    ACT_MASK    = 3'd2,
    ACT_DISPATCH= 3'd3,
    ACT_DONE    = 3'd4,
    ACT_CONSUME = 3'd5,
    ACT_READ    = 3'd6
  } action_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_DISCARD = 3'd2,
    ST_TERM    = 3'd3,
    ST_NONE    = 3'd4,
    ST_FULL    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    K_DEFAULT = 2'd0,
    K_IGNORE  = 2'd1,
    K_CATCH   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    HOW_BLOCK   = 2'd0,
    HOW_UNBLOCK = 2'd1,
    HOW_REPLACE = 2'd2
  } how_t;

  // one disposition table entry
  typedef struct packed {
    logic             info;
    logic             no_defer;
    logic             reset;
    logic [1:0]       kind;
  } disp_flags_t;

  typedef struct packed {
    disp_flags_t      flags;
    logic [SET_W-1:0] hmask;
  } disp_entry_t;

  // value as it may stand in the blocked mask
  function automatic logic [SET_W-1:0] blockable(input logic [SET_W-1:0] m);
    return m & VALID_MASK & ~UNBLOCKABLE;
  endfunction

  // priority encoder, lowest set bit wins
  function automatic logic [SIGNUM_W-1:0] lowest_idx(input logic [SET_W-1:0] m);
    logic [SIGNUM_W-1:0] idx;
    idx = SIGNUM_W'(SET_W - 1);
    for (int i = SET_W - 1; i >= 0; i--) begin
      if (m[i]) idx = SIGNUM_W'(i);
    end
    return idx;
  endfunction

endpackage

// ----- sv/signal_delivery_controller_unit.sv -----
// result beat is registered in the EXEC state after the input beat is accepted and held
//   while out_ready stays low; EXEC waits (with the input closed) while an earlier result is held
// the unit takes no new input beat until the previous one has executed, since the
//   disposition table read (synchronous RAM) comes ahead of the read-modify-write
// reset: pending/blocked masks and nesting level clear; table entries read as
//   default through per-entry valid flags, so no clearing pass is needed
module signal_delivery_controller_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  in_action,
  input  logic [sdc_pkg::SIGNUM_W-1:0] in_signal_number,
  input  logic [sdc_pkg::SET_W-1:0]   in_signal_set,
  input  logic [1:0]                  in_mask_how,
  input  logic [1:0]                  in_handler_kind,
  input  logic                        in_reset_on_entry,
  input  logic                        in_no_defer,
  input  logic                        in_info_style,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  out_status,
  output logic [sdc_pkg::SIGNUM_W-1:0] out_chosen_signal,
  output logic                        out_call_with_info,
  output logic [sdc_pkg::SET_W-1:0]   out_mask_out,
  output logic [1:0]                  out_old_kind,
  output logic                        out_old_reset,
  output logic                        out_old_no_defer,
  output logic                        out_old_info
);
  import sdc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t              state_r;
  logic [2:0]          act_r;
  logic [SIGNUM_W-1:0] sig_r;
  logic [SET_W-1:0]    set_r;
  logic [1:0]          how_r;
  logic [1:0]          kind_r;
  logic                new_reset_r, new_nodef_r, new_info_r;
  logic                hit_r;
  logic [SIGNUM_W-1:0] idx_r;

  logic [SET_W-1:0]    pending_r, pending_nxt;
  logic [SET_W-1:0]    blocked_r, blocked_nxt;
  logic [LVL_W-1:0]    level_r, level_nxt;
  logic [NUM_SIGNALS-1:0] disp_vld_r;
  logic [SIG_W-1:0]    disp_raddr_r;

  logic                out_valid_r;
  logic [2:0]          out_status_r, out_status_nxt;
  logic [SIGNUM_W-1:0] out_chosen_r, out_chosen_nxt;
  logic                out_info_r, out_info_nxt;
  logic [SET_W-1:0]    out_mask_r, out_mask_nxt;
  logic [1:0]          out_okind_r, out_okind_nxt;
  logic                out_oreset_r, out_oreset_nxt;
  logic                out_onodef_r, out_onodef_nxt;
  logic                out_oinfo_r, out_oinfo_nxt;

  logic                accept, exec_go;
  logic [SET_W-1:0]    search;
  logic [SIGNUM_W-1:0] search_idx;
  logic [SIG_W-1:0]    disp_raddr;
  logic [LVL_W-1:0]    level_dec;

  logic                disp_we;
  logic [SIG_W-1:0]    disp_waddr;
  disp_entry_t         disp_wdata, disp_ram_q, disp_rd;
  logic                stk_we;
  logic [SET_W-1:0]    stk_rdata;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign exec_go  = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  // lookup at accept: one encoder for dispatch and consume
  assign search     = (action_t'(in_action) == ACT_CONSUME) ?
                      (pending_r & in_signal_set) : (pending_r & ~blocked_r & VALID_MASK);
  assign search_idx = lowest_idx(search);
  assign disp_raddr = (action_t'(in_action) == ACT_SETDISP) ?
                      in_signal_number[SIG_W-1:0] : search_idx[SIG_W-1:0];
  assign level_dec  = level_r - 1'b1;

  // disposition table: flags and handler mask per signal
  sdc_ram #(.WIDTH(DISP_W), .DEPTH(NUM_SIGNALS)) u_disp_ram (
    .clk   (clk),
    .we    (disp_we),
    .waddr (disp_waddr),
    .wdata (disp_wdata),
    .re    (accept),
    .raddr (disp_raddr),
    .rdata (disp_ram_q)
  );

  // saved blocked masks for nested handlers
  sdc_ram #(.WIDTH(SET_W), .DEPTH(NEST_DEPTH)) u_stk_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (level_r[STK_AW-1:0]),
    .wdata (blocked_r),
    .re    (accept),
    .raddr (level_dec[STK_AW-1:0]),
    .rdata (stk_rdata)
  );

  // never-written entries read as default
  assign disp_rd = disp_vld_r[disp_raddr_r] ? disp_ram_q : '0;

  // execute: read data in hand, compute result and write back
  always_comb begin
    logic             bad_sig;
    logic [SET_W-1:0] sbit;
    logic [SET_W-1:0] cbit;
    pending_nxt    = pending_r;
    blocked_nxt    = blocked_r;
    level_nxt      = level_r;
    disp_we        = 1'b0;
    disp_waddr     = sig_r[SIG_W-1:0];
    disp_wdata     = disp_rd;
    stk_we         = 1'b0;
    out_status_nxt = ST_OK;
    out_chosen_nxt = '0;
    out_info_nxt   = 1'b0;
    out_mask_nxt   = '0;
    out_okind_nxt  = '0;
    out_oreset_nxt = 1'b0;
    out_onodef_nxt = 1'b0;
    out_oinfo_nxt  = 1'b0;
    sbit    = 64'd1 << sig_r;
    cbit    = 64'd1 << idx_r;
    bad_sig = (sig_r == '0) || ({1'b0, sig_r} >= (SIGNUM_W + 1)'(NUM_SIGNALS)) ||
              (sig_r == SIG_KILL) || (sig_r == SIG_STOP) || (kind_r > K_CATCH);

    unique case (action_t'(act_r))
      ACT_POST: begin
        pending_nxt = pending_r | (set_r & VALID_MASK);
      end
      ACT_SETDISP: begin
        if (bad_sig) begin
          out_status_nxt = ST_INVALID;
        end else begin
          out_okind_nxt        = disp_rd.flags.kind;
          out_oreset_nxt       = disp_rd.flags.reset;
          out_onodef_nxt       = disp_rd.flags.no_defer;
          out_oinfo_nxt        = disp_rd.flags.info;
          out_mask_nxt         = disp_rd.hmask;
          disp_we              = 1'b1;
          disp_wdata.flags     = '{info: new_info_r, no_defer: new_nodef_r,
                                   reset: new_reset_r, kind: kind_r};
          disp_wdata.hmask     = set_r;
          // newly ignored signal drops out of the pending set
          if ((kind_t'(kind_r) == K_IGNORE) ||
              ((kind_t'(kind_r) == K_DEFAULT) && ((DFL_IGN & sbit) != '0))) begin
            pending_nxt = pending_r & ~sbit;
          end
        end
      end
      ACT_MASK: begin
        out_mask_nxt = blocked_r;
        unique case (how_r)
          HOW_BLOCK:   blocked_nxt = blockable(blocked_r | set_r);
          HOW_UNBLOCK: blocked_nxt = blockable(blocked_r & ~set_r);
          HOW_REPLACE: blocked_nxt = blockable(set_r);
          default:     out_status_nxt = ST_INVALID;
        endcase
      end
      ACT_DISPATCH: begin
        if (!hit_r) begin
          out_status_nxt = ST_NONE;
        end else begin
          out_chosen_nxt = idx_r;
          if ((kind_t'(disp_rd.flags.kind) == K_CATCH) &&
              (level_r >= LVL_W'(NEST_DEPTH))) begin
            out_status_nxt = ST_FULL;
          end else begin
            pending_nxt = pending_r & ~cbit;
            if (kind_t'(disp_rd.flags.kind) == K_IGNORE) begin
              out_status_nxt = ST_DISCARD;
            end else if (kind_t'(disp_rd.flags.kind) != K_CATCH) begin
              out_status_nxt = ((DFL_IGN & cbit) != '0) ? ST_DISCARD : ST_TERM;
            end else begin
              // delivery: save mask, widen it, maybe revert disposition
              out_info_nxt = disp_rd.flags.info;
              out_mask_nxt = blocked_r;
              if (disp_rd.flags.reset) begin
                disp_we                   = 1'b1;
                disp_waddr                = idx_r[SIG_W-1:0];
                disp_wdata.flags.kind     = K_DEFAULT;
                disp_wdata.flags.info     = 1'b0;
              end
              stk_we      = 1'b1;
              level_nxt   = level_r + 1'b1;
              blocked_nxt = blockable(blocked_r | disp_rd.hmask |
                                      (disp_rd.flags.no_defer ? '0 : cbit));
            end
          end
        end
      end
      ACT_DONE: begin
        if (level_r == '0) begin
          out_status_nxt = ST_INVALID;
        end else begin
          out_mask_nxt = blocked_r;
          level_nxt    = level_dec;
          blocked_nxt  = blockable(stk_rdata);
        end
      end
      ACT_CONSUME: begin
        if (!hit_r) begin
          out_status_nxt = ST_NONE;
        end else begin
          out_chosen_nxt = idx_r;
          pending_nxt    = pending_r & ~cbit;
        end
      end
      ACT_READ: begin
        out_mask_nxt = pending_r & blocked_r;
      end
      default: begin
        out_status_nxt = ST_INVALID;
      end
    endcase

    // only commit when the result register takes it
    if (!exec_go) begin
      disp_we = 1'b0;
      stk_we  = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pending_r   <= '0;
      blocked_r   <= '0;
      level_r     <= '0;
      disp_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: if (accept) state_r <= S_EXEC;
        S_EXEC: if (exec_go) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
      if (exec_go) begin
        pending_r <= pending_nxt;
        blocked_r <= blocked_nxt;
        level_r   <= level_nxt;
      end
      if (disp_we) disp_vld_r[disp_waddr] <= 1'b1;
      if (exec_go) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // captured input beat and lookup results
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r        <= in_action;
      sig_r        <= in_signal_number;
      set_r        <= in_signal_set;
      how_r        <= in_mask_how;
      kind_r       <= in_handler_kind;
      new_reset_r  <= in_reset_on_entry;
      new_nodef_r  <= in_no_defer;
      new_info_r   <= in_info_style;
      hit_r        <= (search != '0);
      idx_r        <= search_idx;
      disp_raddr_r <= disp_raddr;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (exec_go) begin
      out_status_r <= out_status_nxt;
      out_chosen_r <= out_chosen_nxt;
      out_info_r   <= out_info_nxt;
      out_mask_r   <= out_mask_nxt;
      out_okind_r  <= out_okind_nxt;
      out_oreset_r <= out_oreset_nxt;
      out_onodef_r <= out_onodef_nxt;
      out_oinfo_r  <= out_oinfo_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_chosen_signal  = out_chosen_r;
  assign out_call_with_info = out_info_r;
  assign out_mask_out       = out_mask_r;
  assign out_old_kind       = out_okind_r;
  assign out_old_reset      = out_oreset_r;
  assign out_old_no_defer   = out_onodef_r;
  assign out_old_info       = out_oinfo_r;

endmodule

// ----- sv/sdc_ram.sv -----
module sdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

// ----- dv/tb_top.sv -----
module tb_top;
  import sdc_pkg::*;

  // codes the package enums leave out
  localparam logic [2:0] ACT_UNUSED = 3'd7;
  localparam logic [1:0] HOW_BAD    = 2'd3;
  localparam logic [1:0] KIND_BAD   = 2'd3;

  localparam logic [SET_W-1:0] ALL_ONES = {SET_W{1'b1}};
  localparam logic [SET_W-1:0] BLOCK_OK = VALID_MASK & ~UNBLOCKABLE;
  localparam logic [SET_W-1:0] CHLD_BIT = 64'd1 << SIG_CHLD;

  localparam int RANDOM_BEATS = 1450;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [2:0]          action;
    logic [SIGNUM_W-1:0] sig;
    logic [SET_W-1:0]    sigs;
    logic [1:0]          how;
    logic [1:0]          kind;
    logic                reset_entry;
    logic                no_defer;
    logic                info;
  } item_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [SIGNUM_W-1:0] chosen;
    logic                info;
    logic [SET_W-1:0]    mask;
    logic [1:0]          old_kind;
    logic                old_reset;
    logic                old_no_defer;
    logic                old_info;
  } res_t;

  typedef struct packed {
    item_t it;
    bit    typed;
    res_t  want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [2:0]          in_action = '0;
  logic [SIGNUM_W-1:0] in_signal_number = '0;
  logic [SET_W-1:0]    in_signal_set = '0;
  logic [1:0]          in_mask_how = '0;
  logic [1:0]          in_handler_kind = '0;
  logic                in_reset_on_entry = 1'b0;
  logic                in_no_defer = 1'b0;
  logic                in_info_style = 1'b0;

  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [2:0]          out_status;
  logic [SIGNUM_W-1:0] out_chosen_signal;
  logic                out_call_with_info;
  logic [SET_W-1:0]    out_mask_out;
  logic [1:0]          out_old_kind;
  logic                out_old_reset;
  logic                out_old_no_defer;
  logic                out_old_info;

  // typed expectation travels with its beat
  bit   beat_typed = 1'b0;
  res_t beat_want = '0;

  // traffic shaping
  bit calm = 1'b0;
  int hold_asks = 0;
  int holds_served = 0;
  int hold_left = 0;
  int n_beats = 0;

  res_t due_outcomes[$];
  int   mismatches = 0;
  row_t dir_rows[$];

  // shadow controller state
  logic [SET_W-1:0] sig_pend = '0;
  logic [SET_W-1:0] sig_blk = '0;
  disp_flags_t      disp_tab [NUM_SIGNALS] = '{default: '0};
  logic [SET_W-1:0] hmask_tab [NUM_SIGNALS] = '{default: '0};
  logic [SET_W-1:0] save_stk [NEST_DEPTH];
  int               nest_lvl = 0;

  signal_delivery_controller_unit i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_signal_number   (in_signal_number),
    .in_signal_set      (in_signal_set),
    .in_mask_how        (in_mask_how),
    .in_handler_kind    (in_handler_kind),
    .in_reset_on_entry  (in_reset_on_entry),
    .in_no_defer        (in_no_defer),
    .in_info_style      (in_info_style),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_chosen_signal  (out_chosen_signal),
    .out_call_with_info (out_call_with_info),
    .out_mask_out       (out_mask_out),
    .out_old_kind       (out_old_kind),
    .out_old_reset      (out_old_reset),
    .out_old_no_defer   (out_old_no_defer),
    .out_old_info       (out_old_info)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // lowest set bit of a signal set
  function automatic int first_signal(logic [SET_W-1:0] m);
    for (int i = 0; i < SET_W; i++) begin
      if (m[i]) return i;
    end
    return SET_W - 1;
  endfunction

  // outcome of one beat, advancing the shadow state
  function automatic res_t next_outcome(item_t it);
    res_t             r;
    disp_flags_t      f;
    disp_flags_t      nf;
    logic [SET_W-1:0] rdy;
    logic [SET_W-1:0] self_bit;
    int               s;
    r = '0;
    r.status = ST_OK;
    case (it.action)
      ACT_POST: sig_pend = sig_pend | (it.sigs & VALID_MASK);
      ACT_SETDISP: begin
        if (it.sig == 0 || int'(it.sig) >= NUM_SIGNALS || it.sig == SIG_KILL ||
            it.sig == SIG_STOP || it.kind > K_CATCH) begin
          r.status = ST_INVALID;
        end else begin
          f = disp_tab[it.sig];
          r.old_kind = f.kind;
          r.old_reset = f.reset;
          r.old_no_defer = f.no_defer;
          r.old_info = f.info;
          r.mask = hmask_tab[it.sig];
          nf.kind = it.kind;
          nf.reset = it.reset_entry;
          nf.no_defer = it.no_defer;
          nf.info = it.info;
          disp_tab[it.sig] = nf;
          hmask_tab[it.sig] = it.sigs;
          // a newly ignored signal drops out of the pending set
          if (it.kind == K_IGNORE || (it.kind == K_DEFAULT && DFL_IGN[it.sig])) begin
            sig_pend[it.sig] = 1'b0;
          end
        end
      end
      ACT_MASK: begin
        r.mask = sig_blk;
        case (it.how)
          HOW_BLOCK:   sig_blk = (sig_blk | it.sigs) & BLOCK_OK;
          HOW_UNBLOCK: sig_blk = (sig_blk & ~it.sigs) & BLOCK_OK;
          HOW_REPLACE: sig_blk = it.sigs & BLOCK_OK;
          default:     r.status = ST_INVALID;
        endcase
      end
      ACT_DISPATCH: begin
        rdy = sig_pend & ~sig_blk & VALID_MASK;
        if (rdy == '0) begin
          r.status = ST_NONE;
        end else begin
          s = first_signal(rdy);
          r.chosen = SIGNUM_W'(s);
          f = disp_tab[s];
          if (f.kind == K_CATCH && nest_lvl >= NEST_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            sig_pend[s] = 1'b0;
            if (f.kind == K_IGNORE) begin
              r.status = ST_DISCARD;
            end else if (f.kind != K_CATCH) begin
              r.status = DFL_IGN[s] ? ST_DISCARD : ST_TERM;
            end else begin
              // delivery: save the mask, then widen it
              r.info = f.info;
              r.mask = sig_blk;
              if (f.reset) begin
                disp_tab[s].kind = K_DEFAULT;
                disp_tab[s].info = 1'b0;
              end
              save_stk[nest_lvl % NEST_DEPTH] = sig_blk;
              nest_lvl++;
              self_bit = '0;
              if (!f.no_defer) self_bit[s] = 1'b1;
              sig_blk = (sig_blk | hmask_tab[s] | self_bit) & BLOCK_OK;
            end
          end
        end
      end
      ACT_DONE: begin
        if (nest_lvl == 0) begin
          r.status = ST_INVALID;
        end else begin
          r.mask = sig_blk;
          nest_lvl--;
          sig_blk = save_stk[nest_lvl % NEST_DEPTH] & BLOCK_OK;
        end
      end
      ACT_CONSUME: begin
        rdy = sig_pend & it.sigs;
        if (rdy == '0) begin
          r.status = ST_NONE;
        end else begin
          s = first_signal(rdy);
          r.chosen = SIGNUM_W'(s);
          sig_pend[s] = 1'b0;
        end
      end
      ACT_READ: r.mask = sig_pend & sig_blk;
      default:  r.status = ST_INVALID;
    endcase
    return r;
  endfunction

  function automatic item_t mk_item(logic [2:0] action, logic [SIGNUM_W-1:0] sig,
                                    logic [SET_W-1:0] sigs, logic [1:0] how,
                                    logic [1:0] kind, logic [2:0] fl);
    item_t it;
    it.action = action;
    it.sig = sig;
    it.sigs = sigs;
    it.how = how;
    it.kind = kind;
    {it.reset_entry, it.no_defer, it.info} = fl;
    return it;
  endfunction

  // fl is {reset_on_entry, no_defer, info_style}; typed rows carry status, signal, mask
  function automatic row_t mk_row(logic [2:0] action, logic [SIGNUM_W-1:0] sig,
                                  logic [SET_W-1:0] sigs, logic [1:0] how,
                                  logic [1:0] kind, logic [2:0] fl, bit typed,
                                  logic [2:0] st, logic [SIGNUM_W-1:0] ch,
                                  logic [SET_W-1:0] m);
    row_t rw;
    rw.it = mk_item(action, sig, sigs, how, kind, fl);
    rw.typed = typed;
    rw.want = '0;
    rw.want.status = st;
    rw.want.chosen = ch;
    rw.want.mask = m;
    return rw;
  endfunction

  function automatic logic [SET_W-1:0] rand_set();
    int               r;
    logic [SET_W-1:0] v;
    r = $urandom_range(99);
    v = '0;
    if (r < 35) begin
      v[$urandom_range(SET_W - 1)] = 1'b1;
    end else if (r < 55) begin
      v[$urandom_range(SET_W - 1)] = 1'b1;
      v[$urandom_range(SET_W - 1)] = 1'b1;
      v[$urandom_range(SET_W - 1)] = 1'b1;
    end else if (r < 80) begin
      v = {$urandom, $urandom};
    end else if (r < 86) begin
      v = ALL_ONES;
    end else if (r >= 92) begin
      v = SET_W'($urandom_range(65535));
    end
    return v;
  endfunction

  function automatic logic [SIGNUM_W-1:0] rand_sig();
    if ($urandom_range(99) < 15) begin
      case ($urandom_range(6))
        0:       return '0;
        1:       return SIG_KILL;
        2:       return SIG_STOP;
        3:       return SIG_CHLD;
        4:       return SIG_URG;
        5:       return SIG_WINCH;
        default: return '1;
      endcase
    end
    return SIGNUM_W'($urandom_range(1, NUM_SIGNALS - 1));
  endfunction

  // catchable signal for well-formed handler sequences
  function automatic logic [SIGNUM_W-1:0] rand_catchable();
    logic [SIGNUM_W-1:0] s;
    do begin
      s = SIGNUM_W'($urandom_range(1, NUM_SIGNALS - 1));
    end while (s == SIG_KILL || s == SIG_STOP);
    return s;
  endfunction

  function automatic item_t rand_item();
    int         r;
    logic [2:0] action;
    logic [1:0] kind;
    r = $urandom_range(99);
    if (r < 18)      action = ACT_POST;
    else if (r < 33) action = ACT_SETDISP;
    else if (r < 45) action = ACT_MASK;
    else if (r < 65) action = ACT_DISPATCH;
    else if (r < 77) action = ACT_DONE;
    else if (r < 85) action = ACT_CONSUME;
    else if (r < 95) action = ACT_READ;
    else             action = ACT_UNUSED;
    kind = ($urandom_range(9) == 0) ? KIND_BAD : 2'($urandom_range(2));
    return mk_item(action, rand_sig(), rand_set(), 2'($urandom_range(3)), kind,
                   3'($urandom_range(7)));
  endfunction

  // wait until every expected result has come back
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_outcomes.size() != 0);
  endtask

  // offer one beat and hold it until accepted
  task automatic send_beat(item_t it, bit typed, res_t want);
    int gap;
    gap = (!calm && $urandom_range(99) < 17) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= it.action;
    in_signal_number <= it.sig;
    in_signal_set <= it.sigs;
    in_mask_how <= it.how;
    in_handler_kind <= it.kind;
    in_reset_on_entry <= it.reset_entry;
    in_no_defer <= it.no_defer;
    in_info_style <= it.info;
    beat_typed <= typed;
    beat_want <= want;
    do @(posedge clk); while (!in_ready);
    n_beats++;
    if (n_beats == 300) hold_asks <= hold_asks + 1;
    calm <= (n_beats >= 1000 && n_beats < 1250);
    if (n_beats == 800) settle();
  endtask

  // receiver: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_asks != holds_served) begin
      out_ready <= 1'b0;
      holds_served <= holds_served + 1;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 17);
    end
  end

  task automatic cmp_field(string name, logic [SET_W-1:0] exp_v, logic [SET_W-1:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // predict on input beats, check result beats in order
  always @(posedge clk) begin : scoreboard
    item_t beat;
    res_t  want;
    res_t  got;
    if (rst_n && in_valid && in_ready) begin
      beat.action = in_action;
      beat.sig = in_signal_number;
      beat.sigs = in_signal_set;
      beat.how = in_mask_how;
      beat.kind = in_handler_kind;
      beat.reset_entry = in_reset_on_entry;
      beat.no_defer = in_no_defer;
      beat.info = in_info_style;
      want = next_outcome(beat);
      if (beat_typed) want = beat_want;
      due_outcomes.push_back(want);
    end
    if (rst_n && out_valid && out_ready) begin
      if (due_outcomes.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with no expectation waiting, status %h", $time,
                 out_status);
      end else begin
        want = due_outcomes.pop_front();
        got.status = out_status;
        got.chosen = out_chosen_signal;
        got.info = out_call_with_info;
        got.mask = out_mask_out;
        got.old_kind = out_old_kind;
        got.old_reset = out_old_reset;
        got.old_no_defer = out_old_no_defer;
        got.old_info = out_old_info;
        cmp_field("status", SET_W'(want.status), SET_W'(got.status));
        cmp_field("chosen_signal", SET_W'(want.chosen), SET_W'(got.chosen));
        cmp_field("call_with_info", SET_W'(want.info), SET_W'(got.info));
        cmp_field("mask_out", want.mask, got.mask);
        cmp_field("old_kind", SET_W'(want.old_kind), SET_W'(got.old_kind));
        cmp_field("old_reset", SET_W'(want.old_reset), SET_W'(got.old_reset));
        cmp_field("old_no_defer", SET_W'(want.old_no_defer), SET_W'(got.old_no_defer));
        cmp_field("old_info", SET_W'(want.old_info), SET_W'(got.old_info));
      end
    end
  end

  // stimulus
  initial begin : stim
    item_t            it;
    int               k;
    logic [SET_W-1:0] members;
    logic [SIGNUM_W-1:0] s;

    dir_rows = '{
      mk_row(ACT_READ, '0, '0, HOW_BLOCK, K_DEFAULT, 3'b000, 1, ST_OK, '0, '0),
      mk_row(ACT_DISPATCH, '0, '0, HOW_BLOCK, K_DEFAULT, 3'b000, 1, ST_NONE, '0, '0),
      mk_row(ACT_DONE, '0, '0, HOW_BLOCK, K_DEFAULT, 3'b000, 1, ST_INVALID, '0, '0),
      mk_row(ACT_UNUSED, '1, ALL_ONES, HOW_BAD, KIND_BAD, 3'b111, 1, ST_INVALID, '0, '0),
      mk_row(ACT_SETDISP, '0, ALL_ONES, HOW_BLOCK, K_CATCH, 3'b111, 1, ST_INVALID, '0, '0),
      mk_row(ACT_SETDISP, SIG_KILL, '0, HOW_BLOCK, K_CATCH, 3'b000, 1, ST_INVALID, '0, '0),
      mk_row(ACT_SETDISP, SIG_STOP, '0, HOW_BLOCK, K_IGNORE, 3'b000, 1, ST_INVALID, '0, '0),
      mk_row(ACT_SETDISP, 6'd5, '0, HOW_BLOCK, KIND_BAD, 3'b000, 1, ST_INVALID, '0, '0),
      mk_row(ACT_MASK, '0, ALL_ONES, HOW_BAD, K_DEFAULT, 3'b000, 1, ST_INVALID, '0, '0),
      // every blockable signal blocked, signal zero and kill/stop dropped
      mk_row(ACT_MASK, '0, ALL_ONES, HOW_BLOCK, K_DEFAULT, 3'b000, 1, ST_OK, '0, '0),
      mk_row(ACT_POST, '0, ALL_ONES, HOW_BLOCK, K_DEFAULT, 3'b000, 1, ST_OK, '0, '0),
      mk_row(ACT_READ, '0, '0, HOW_BLOCK, K_DEFAULT, 3'b000, 1, ST_OK, '0, BLOCK_OK),
      // only the unblockable ones get through, both terminate
      mk_row(ACT_DISPATCH, '0, '0, HOW_BLOCK, K_DEFAULT, 3'b000, 1, ST_TERM, SIG_KILL, '0),
      mk_row(ACT_DISPATCH, '0, '0, HOW_BLOCK, K_DEFAULT, 3'b000, 1, ST_TERM, SIG_STOP, '0),
      mk_row(ACT_DISPATCH, '0, '0, HOW_BLOCK, K_DEFAULT, 3'b000, 1, ST_NONE, '0, '0),
      // catch with reset on entry and info form, handler mask at both ends
      mk_row(ACT_SETDISP, SIG_CHLD, 64'h8000_0000_0000_0001, HOW_BLOCK, K_CATCH, 3'b101,
             1, ST_OK, '0, '0),
      mk_row(ACT_MASK, '0, ~CHLD_BIT, HOW_REPLACE, K_DEFAULT, 3'b000, 1, ST_OK, '0, BLOCK_OK),
      mk_row(ACT_DISPATCH, '0, '0, HOW_BLOCK, K_DEFAULT, 3'b000, 0, ST_OK, '0, '0),
      mk_row(ACT_SETDISP, SIG_CHLD, '0, HOW_BLOCK, K_DEFAULT, 3'b000, 0, ST_OK, '0, '0),
      // newly ignored signal leaves the pending set
      mk_row(ACT_SETDISP, SIG_URG, ALL_ONES, HOW_BLOCK, K_IGNORE, 3'b010, 0, ST_OK, '0, '0),
      mk_row(ACT_DONE, '0, '0, HOW_BLOCK, K_DEFAULT, 3'b000, 0, ST_OK, '0, '0),
      mk_row(ACT_CONSUME, '0, ALL_ONES, HOW_BLOCK, K_DEFAULT, 3'b000, 0, ST_OK, '0, '0),
      mk_row(ACT_CONSUME, '0, '0, HOW_BLOCK, K_DEFAULT, 3'b000, 1, ST_NONE, '0, '0),
      // unblocking does not dispatch by itself
      mk_row(ACT_MASK, '0, ALL_ONES, HOW_UNBLOCK, K_DEFAULT, 3'b000, 0, ST_OK, '0, '0),
      mk_row(ACT_READ, '0, '0, HOW_BLOCK, K_DEFAULT, 3'b000, 1, ST_OK, '0, '0)
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (dir_rows[i]) send_beat(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
    settle();

    // random: handler sequences with random content, plus noise
    while (n_beats < dir_rows.size() + RANDOM_BEATS) begin
      if ($urandom_range(99) < 45) begin
        k = $urandom_range(1, 10);
        members = '0;
        repeat (k) begin
          s = rand_catchable();
          members[s] = 1'b1;
          it = mk_item(ACT_SETDISP, s, '0, HOW_BLOCK, K_CATCH, 3'($urandom_range(7)));
          if ($urandom_range(1)) it.sigs[$urandom_range(SET_W - 1)] = 1'b1;
          send_beat(it, 0, '0);
        end
        send_beat(mk_item(ACT_POST, '0, members, HOW_BLOCK, K_DEFAULT, 3'b000), 0, '0);
        repeat (k + 2) begin
          if ($urandom_range(99) < 15) it = rand_item();
          else it = mk_item(ACT_DISPATCH, rand_sig(), rand_set(), 2'($urandom_range(3)),
                            2'($urandom_range(3)), 3'($urandom_range(7)));
          send_beat(it, 0, '0);
        end
        repeat ($urandom_range(0, k + 1)) begin
          send_beat(mk_item(ACT_DONE, rand_sig(), rand_set(), 2'($urandom_range(3)),
                            2'($urandom_range(3)), 3'($urandom_range(7))), 0, '0);
        end
      end else begin
        repeat (20) send_beat(rand_item(), 0, '0);
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && due_outcomes.size() == 0) begin
      $display("signal_delivery_controller_unit regression: pass");
    end else begin
      $display("signal_delivery_controller_unit regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("signal_delivery_controller_unit regression: fail");
    $finish;
  end

endmodule

// ----- signal_delivery_controller_unit.f -----
sv/sdc_pkg.sv
sv/sdc_ram.sv
sv/signal_delivery_controller_unit.sv
dv/tb_top.sv
